/* rtl/pst_pkg.sv */
// Package for the peer session table: field widths, operation and status codes,
// controller state encoding and the default table depth. No dependencies.
`default_nettype none

package pst_pkg;

  localparam int unsigned TableDepthDef = 16;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 16;
  localparam int unsigned NumW   = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 2;

  localparam int unsigned InDataW  = AddrW + PortW + NumW;
  localparam int unsigned OutDataW = NumW + CountW;

  typedef enum logic [OpW-1:0] {
    OP_ADD       = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_LOOKUP    = 2'd2,
    OP_INCREMENT = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

/* rtl/peer_session_table.sv */
// Peer session table: entries keyed by peer IPv4 address and port, held in one
// synchronous memory with a read-modify-write sweep controller. Depends on pst_pkg.
`default_nettype none

// The table holds TABLE_DEPTH entries in a single memory with one read and one
// write port. Every request except an add to a full table walks all slots through
// that read port. A remove that finds its entry walks the table a second time to
// renumber entry ages, and an add to a full table skips the walk. Add stores a new
// entry with a message count of one in the lowest free slot without checking for
// duplicates, and every search acts on the newest matching entry. A result item
// waits in an output register while the next request is already being worked on.
// That request is held in its last cycle, and the input stays stalled, until the
// output register is free.

module peer_session_table
  import pst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata from bit 0: peer_address[31:0], peer_port[15:0], new_number[15:0].
  input  wire  [InDataW-1:0]  s_axis_tdata,
  // tuser from bit 0: operation[1:0].
  input  wire  [OpW-1:0]      s_axis_tuser,
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // tdata from bit 0: found_number[15:0], message_count[31:0].
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser from bit 0: status[1:0].
  output logic [StatW-1:0]    m_axis_tuser
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [PortW-1:0]  port;
    logic [NumW-1:0]   number;
    logic [CountW-1:0] count;
    logic [IdxW-1:0]   recency;
  } entry_t;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_data_q;
  logic   rd_en;
  logic [IdxW-1:0] rd_idx;
  logic   mem_we;
  logic [IdxW-1:0] wr_idx;
  entry_t wr_data;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [PortW-1:0] port_q, port_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [CntW-1:0]  issue_q, issue_d;
  logic             proc_vld_q, proc_vld_d;
  logic [IdxW-1:0]  proc_idx_q, proc_idx_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  entry_t           best_q, best_d;
  logic             placed_q, placed_d;
  status_e          status_q, status_d;
  logic [NumW-1:0]  res_num_q, res_num_d;
  logic [CountW-1:0] res_cnt_q, res_cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  status_e          out_status_q;
  logic [NumW-1:0]  out_num_q;
  logic [CountW-1:0] out_cnt_q;

  logic            proc_last;
  logic            key_match;
  logic            better;
  logic            hit_now;
  logic [IdxW-1:0] best_idx_now;
  entry_t          best_now;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx];
    end
  end

  assign rd_en  = ((state_q == S_SCAN) || (state_q == S_SWEEP)) && (issue_q != DepthC);
  assign rd_idx = issue_q[IdxW-1:0];

  assign proc_last    = proc_vld_q && (proc_idx_q == LastIdx);
  assign key_match    = proc_vld_q && valid_q[proc_idx_q] &&
                        (rd_data_q.addr == addr_q) && (rd_data_q.port == port_q);
  assign better       = key_match && (!hit_q || (rd_data_q.recency < best_q.recency));
  assign hit_now      = hit_q || better;
  assign best_idx_now = better ? proc_idx_q : best_idx_q;
  assign best_now     = better ? rd_data_q : best_q;

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    port_d      = port_q;
    num_d       = num_q;
    issue_d     = rd_en ? (issue_q + CntW'(1)) : issue_q;
    proc_vld_d  = rd_en;
    proc_idx_d  = rd_idx;
    valid_d     = valid_q;
    fill_d      = fill_q;
    hit_d       = hit_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    placed_d    = placed_q;
    status_d    = status_q;
    res_num_d   = res_num_q;
    res_cnt_d   = res_cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    wr_idx      = proc_idx_q;
    wr_data     = rd_data_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d      = op_e'(s_axis_tuser);
          addr_d    = s_axis_tdata[AddrW-1:0];
          port_d    = s_axis_tdata[AddrW+PortW-1:AddrW];
          num_d     = s_axis_tdata[InDataW-1:AddrW+PortW];
          issue_d   = '0;
          hit_d     = 1'b0;
          placed_d  = 1'b0;
          status_d  = ST_OK;
          res_num_d = '0;
          res_cnt_d = '0;
          if (op_e'(s_axis_tuser) == OP_ADD) begin
            if (fill_q == DepthC) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              state_d = S_SWEEP;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (better) begin
          hit_d      = 1'b1;
          best_idx_d = proc_idx_q;
          best_d     = rd_data_q;
        end
        if (proc_last) begin
          issue_d = '0;
          state_d = S_DONE;
          if (!hit_now) begin
            status_d = ST_NOT_FOUND;
          end else begin
            case (op_q)
              OP_REMOVE: begin
                valid_d[best_idx_now] = 1'b0;
                fill_d  = fill_q - CntW'(1);
                state_d = S_SWEEP;
              end
              OP_LOOKUP: begin
                res_num_d = best_now.number;
                res_cnt_d = best_now.count;
              end
              OP_INCREMENT: begin
                mem_we        = 1'b1;
                wr_idx        = best_idx_now;
                wr_data       = best_now;
                wr_data.count = best_now.count + CountW'(1);
              end
              default: begin
                status_d = ST_OK;
              end
            endcase
          end
        end
      end
      S_SWEEP: begin
        if (proc_vld_q) begin
          if (valid_q[proc_idx_q]) begin
            if (op_q == OP_ADD) begin
              mem_we          = 1'b1;
              wr_data.recency = rd_data_q.recency + IdxW'(1);
            end else if (rd_data_q.recency > best_q.recency) begin
              mem_we          = 1'b1;
              wr_data.recency = rd_data_q.recency - IdxW'(1);
            end
          end else if ((op_q == OP_ADD) && !placed_q) begin
            mem_we                = 1'b1;
            wr_data.addr          = addr_q;
            wr_data.port          = port_q;
            wr_data.number        = num_q;
            wr_data.count         = CountW'(1);
            wr_data.recency       = '0;
            valid_d[proc_idx_q]   = 1'b1;
            placed_d              = 1'b1;
            fill_d                = fill_q + CntW'(1);
          end
        end
        if (proc_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= '0;
      proc_vld_q  <= 1'b0;
      valid_q     <= '0;
      fill_q      <= '0;
      hit_q       <= 1'b0;
      placed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      proc_vld_q  <= proc_vld_d;
      valid_q     <= valid_d;
      fill_q      <= fill_d;
      hit_q       <= hit_d;
      placed_q    <= placed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    port_q     <= port_d;
    num_q      <= num_d;
    proc_idx_q <= proc_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    status_q   <= status_d;
    res_num_q  <= res_num_d;
    res_cnt_q  <= res_cnt_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_num_q    <= res_num_q;
      out_cnt_q    <= res_cnt_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cnt_q, out_num_q};
  assign m_axis_tuser  = out_status_q;

  a_fill_matches_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fill_q == CntW'($countones(valid_q))
  ) else $error("fill count disagrees with valid bits");

  a_no_write_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we
  ) else $error("memory written while idle");

  a_rw_distinct: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (mem_we && rd_en) |-> (wr_idx != rd_idx)
  ) else $error("read and write of the same entry in one cycle");

  a_full_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_ADD) && (fill_q != DepthC))
    |=> (state_q == S_SWEEP)
  ) else $error("add with a free slot did not start the fill sweep");

endmodule

`default_nettype wire

/* sim/tb_peer_session_table.sv */
// Self-checking testbench for peer_session_table: drives request items on the input stream
// and checks every reply against a predictor of the session table. Depends on pst_pkg.
`timescale 1ns / 100ps

module tb_peer_session_table;
  import pst_pkg::*;

  localparam int unsigned Depth = TableDepthDef;
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned PoolSize = 6;

  typedef struct {
    status_e     st;
    logic [15:0] num;
    logic [31:0] cnt;
  } session_reply_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [OpW-1:0]      s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatW-1:0]    m_axis_tuser;

  logic        tbl_valid [Depth];
  logic [31:0] tbl_addr  [Depth];
  logic [15:0] tbl_port  [Depth];
  logic [15:0] tbl_num   [Depth];
  logic [31:0] tbl_count [Depth];
  int unsigned tbl_age   [Depth];

  session_reply_t pending_replies[$];
  int unsigned    mismatch_count;
  int unsigned    idle_cycles;
  logic           tx_smooth;
  logic           rx_smooth;
  logic           rx_hold_req;
  logic [31:0]    pool_addr [PoolSize];
  logic [15:0]    pool_port [PoolSize];

  peer_session_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic session_reply_t apply_session_request(op_e op, logic [31:0] addr,
                                                          logic [15:0] port,
                                                          logic [15:0] num);
    session_reply_t r;
    int hit;
    int free_slot;
    int unsigned age;
    r.st = ST_OK;
    r.num = '0;
    r.cnt = '0;
    hit = -1;
    free_slot = -1;
    if (op == OP_ADD) begin
      for (int i = Depth - 1; i >= 0; i--) begin
        if (!tbl_valid[i]) free_slot = i;
      end
      if (free_slot < 0) begin
        r.st = ST_FULL;
      end else begin
        for (int i = 0; i < Depth; i++) begin
          if (tbl_valid[i]) tbl_age[i]++;
        end
        tbl_valid[free_slot] = 1'b1;
        tbl_addr[free_slot] = addr;
        tbl_port[free_slot] = port;
        tbl_num[free_slot] = num;
        tbl_count[free_slot] = 32'd1;
        tbl_age[free_slot] = 0;
      end
    end else begin
      for (int i = 0; i < Depth; i++) begin
        if (tbl_valid[i] && tbl_addr[i] == addr && tbl_port[i] == port) begin
          if (hit < 0 || tbl_age[i] < tbl_age[hit]) hit = i;
        end
      end
      if (hit < 0) begin
        r.st = ST_NOT_FOUND;
      end else if (op == OP_REMOVE) begin
        age = tbl_age[hit];
        tbl_valid[hit] = 1'b0;
        for (int i = 0; i < Depth; i++) begin
          if (tbl_valid[i] && tbl_age[i] > age) tbl_age[i]--;
        end
      end else if (op == OP_LOOKUP) begin
        r.num = tbl_num[hit];
        r.cnt = tbl_count[hit];
      end else begin
        tbl_count[hit] = tbl_count[hit] + 32'd1;
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_smooth || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is accepted.
  task automatic offer_request(op_e op, logic [31:0] addr, logic [15:0] port,
                               logic [15:0] num);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {num, port, addr};
    s_axis_tuser = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_replies.push_back(apply_session_request(op, addr, port, num));
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    offer_request(OP_LOOKUP, 32'h0, 16'h0, 16'h0);
    offer_request(OP_REMOVE, 32'h0, 16'h0, 16'h0);
    offer_request(OP_INCREMENT, 32'h0, 16'h0, 16'h0);
    offer_request(OP_ADD, 32'h0, 16'h0, 16'h0);
    offer_request(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    offer_request(OP_LOOKUP, 32'h0, 16'h0, 16'hFFFF);
    offer_request(OP_INCREMENT, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
    offer_request(OP_INCREMENT, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
    offer_request(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
    // A duplicate key shadows the older entry until it is removed.
    offer_request(OP_ADD, 32'h0, 16'h0, 16'h1234);
    offer_request(OP_LOOKUP, 32'h0, 16'h0, 16'h0);
    offer_request(OP_REMOVE, 32'h0, 16'h0, 16'h0);
    offer_request(OP_LOOKUP, 32'h0, 16'h0, 16'h0);
    offer_request(OP_ADD, 32'h0, 16'hFFFF, 16'hA5A5);
    offer_request(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 16'h0);
    offer_request(OP_REMOVE, 32'h0, 16'h0, 16'h0);
    offer_request(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
    offer_request(OP_LOOKUP, 32'h0, 16'hFFFF, 16'h0);
    offer_request(OP_REMOVE, 32'h0, 16'hFFFF, 16'h0);
  endtask

  task automatic test_table_full();
    logic [31:0] addr [Depth];
    logic [15:0] port [Depth];
    for (int i = 0; i < Depth; i++) begin
      addr[i] = $urandom();
      port[i] = 16'($urandom());
      offer_request(OP_ADD, addr[i], port[i], 16'($urandom()));
    end
    offer_request(OP_ADD, 32'($urandom()), 16'($urandom()), 16'($urandom()));
    offer_request(OP_LOOKUP, addr[0], port[0], 16'h0);
    offer_request(OP_REMOVE, addr[Depth / 2], port[Depth / 2], 16'h0);
    offer_request(OP_ADD, addr[1], port[1], 16'($urandom()));
    offer_request(OP_LOOKUP, addr[1], port[1], 16'h0);
    for (int i = 0; i < Depth; i++) begin
      offer_request(OP_REMOVE, addr[i], port[i], 16'h0);
    end
    offer_request(OP_REMOVE, addr[1], port[1], 16'h0);
  endtask

  task automatic test_output_backpressure();
    tx_smooth = 1'b1;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      offer_request(i < 6 ? OP_ADD : OP_LOOKUP, pool_addr[i % PoolSize],
                    pool_port[i % PoolSize], 16'($urandom()));
    end
    tx_smooth = 1'b0;
  endtask

  task automatic test_random(int unsigned phases, int unsigned per_phase);
    int unsigned r;
    int unsigned k;
    op_e op;
    logic [31:0] addr;
    logic [15:0] port;
    for (int p = 0; p < phases; p++) begin
      tx_smooth = ($urandom_range(0, 3) == 0);
      rx_smooth = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < per_phase; n++) begin
        r = $urandom_range(0, 99);
        if (p % 2 == 0) begin
          op = r < 60 ? OP_ADD : r < 75 ? OP_REMOVE : r < 90 ? OP_LOOKUP : OP_INCREMENT;
        end else begin
          op = r < 20 ? OP_ADD : r < 60 ? OP_REMOVE : r < 85 ? OP_LOOKUP : OP_INCREMENT;
        end
        if ($urandom_range(0, 99) < 85) begin
          k = $urandom_range(0, PoolSize - 1);
          addr = pool_addr[k];
          port = pool_port[k];
        end else begin
          op = op_e'($urandom_range(0, 3));
          addr = $urandom();
          port = 16'($urandom());
        end
        offer_request(op, addr, port, 16'($urandom()));
      end
    end
    tx_smooth = 1'b0;
    rx_smooth = 1'b0;
  endtask

  initial begin
    int unsigned stall_left;
    int unsigned r;
    m_axis_tready = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left = RxHoldCycles - 1;
        m_axis_tready = 1'b0;
      end else if (!rx_smooth && $urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, 99);
        stall_left = r < 85 ? $urandom_range(0, 2) : $urandom_range(10, 60);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_reply
    session_reply_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected reply, actual status %0d number %h count %h", $time,
                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16]);
      end else begin
        exp_r = pending_replies.pop_front();
        if (m_axis_tuser !== exp_r.st) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, m_axis_tuser);
        end
        if (m_axis_tdata[15:0] !== exp_r.num) begin
          mismatch_count++;
          $display("%0t: found_number expected %h actual %h", $time, exp_r.num,
                   m_axis_tdata[15:0]);
        end
        if (m_axis_tdata[47:16] !== exp_r.cnt) begin
          mismatch_count++;
          $display("%0t: message_count expected %h actual %h", $time, exp_r.cnt,
                   m_axis_tdata[47:16]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ADD;
    mismatch_count = 0;
    idle_cycles = 0;
    tx_smooth = 1'b0;
    rx_smooth = 1'b0;
    rx_hold_req = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i] = '0;
      tbl_port[i] = '0;
      tbl_num[i] = '0;
      tbl_count[i] = '0;
      tbl_age[i] = 0;
    end
    for (int i = 0; i < PoolSize; i++) begin
      pool_addr[i] = $urandom();
      pool_port[i] = 16'($urandom());
    end
    pool_addr[1] = pool_addr[0];
    pool_port[2] = pool_port[0];
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_table_full();
    test_output_backpressure();
    test_random(8, 42);

    s_axis_tvalid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
